// ----- hw/rtl/sfa_pkg.sv -----
package sfa_pkg;

  localparam int unsigned MaxGrid       = 16;
  localparam int unsigned NumHistograms = 4;
  localparam int unsigned NumTypes      = 4;

  localparam logic [1:0] ModeClear = 2'd0;
  localparam logic [1:0] ModeAccum = 2'd1;
  localparam logic [1:0] ModeRead  = 2'd2;

  localparam logic [2:0] CfgGridSize = 3'd0;
  localparam logic [2:0] CfgDims     = 3'd1;
  localparam logic [2:0] CfgPairMap  = 3'd2;
  localparam logic [2:0] CfgRecipX   = 3'd3;
  localparam logic [2:0] CfgRecipY   = 3'd4;
  localparam logic [2:0] CfgRecipZ   = 3'd5;

  // Taylor coefficients of sin(pi/2*t), Q30
  localparam logic [31:0] Coef1 = 32'd1686629713;
  localparam logic [31:0] Coef3 = 32'd693598669;
  localparam logic [31:0] Coef5 = 32'd85569305;
  localparam logic [31:0] Coef7 = 32'd5026995;
  localparam logic [31:0] Coef9 = 32'd172272;

  typedef struct packed {
    logic [1:0]         mode;
    logic [1:0]         first_type;
    logic [1:0]         second_type;
    logic signed [31:0] disp_x;
    logic signed [31:0] disp_y;
    logic signed [31:0] disp_z;
    logic [11:0]        bin_select;
    logic [1:0]         histogram_select;
  } sfa_in_t;

  typedef struct packed {
    logic signed [47:0] real_sum;
    logic signed [47:0] imag_sum;
  } sfa_out_t;

endpackage

// ----- hw/rtl/structure_factor_accumulator_unit.sv -----
// Structure factor accumulator.
// Input channel (in_valid_i / in_stall_o / in_data_i) takes one beat per item:
// mode 0 clears all sums, mode 1 accumulates one atom pair over every wave
// vector bin, mode 2 reads one bin and returns one beat on the output channel
// (out_valid_o / out_stall_i / out_data_o). Mode 3 is dropped.
// A pair runs the setup step (SPre), then walks the grid one bin at a time:
// phase (SPh), sine and cosine (SSin, Horner; like setup it uses the single
// shared 33x33 multiplier), a check of each histogram (SHist) plus a
// read-modify-write (SHRd, SHWr) per selected histogram, and an index step
// (SOut), over g*g*(g/2+1) bins (g*(g/2+1) planar).
// A clear sweeps the store one entry per cycle; a read passes through SRdA and
// SRdB before out_valid_o rises. After reset the same clearing sweep runs
// while in_stall_o stays high; configuration writes are taken always.
// A read result sits in the output register until taken; while it is pending
// the block does not accept the next item.
module structure_factor_accumulator_unit #(
  parameter int unsigned MAX_GRID       = sfa_pkg::MaxGrid,
  parameter int unsigned NUM_HISTOGRAMS = sfa_pkg::NumHistograms,
  parameter int unsigned NUM_TYPES      = sfa_pkg::NumTypes
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  sfa_pkg::sfa_in_t in_data_i,
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output sfa_pkg::sfa_out_t out_data_o,
  input  logic             cfg_valid_i,
  output logic             cfg_ready_o,
  input  logic [2:0]       cfg_index_i,
  input  logic [63:0]      cfg_data_i
);
  import sfa_pkg::*;

  localparam int unsigned BinCount = MAX_GRID * MAX_GRID * (MAX_GRID / 2 + 1);
  localparam int unsigned BW       = $clog2(BinCount);
  localparam int unsigned HW       = (NUM_HISTOGRAMS > 1) ? $clog2(NUM_HISTOGRAMS) : 1;
  localparam int unsigned Depth    = BinCount * NUM_HISTOGRAMS;
  localparam int unsigned AW       = $clog2(Depth);
  localparam int unsigned GW       = $clog2(MAX_GRID + 1);

  localparam logic [3:0] SIdle  = 4'd0;
  localparam logic [3:0] SClear = 4'd1;
  localparam logic [3:0] SRdA   = 4'd2;
  localparam logic [3:0] SRdB   = 4'd3;
  localparam logic [3:0] SPre   = 4'd4;
  localparam logic [3:0] SPh    = 4'd5;
  localparam logic [3:0] SSin   = 4'd6;
  localparam logic [3:0] SHist  = 4'd7;
  localparam logic [3:0] SHRd   = 4'd8;
  localparam logic [3:0] SHWr   = 4'd9;
  localparam logic [3:0] SOut   = 4'd10;

  // config
  logic [4:0]  grid_q;
  logic [1:0]  dims_q;
  logic [63:0] map_q;
  logic [31:0] rx_q, ry_q, rz_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_q <= 5'd16;
      dims_q <= 2'd3;
      map_q  <= '1;
      rx_q   <= '0;
      ry_q   <= '0;
      rz_q   <= '0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgGridSize: grid_q <= cfg_data_i[4:0];
        CfgDims:     dims_q <= cfg_data_i[1:0];
        CfgPairMap:  map_q  <= cfg_data_i;
        CfgRecipX:   rx_q   <= cfg_data_i[31:0];
        CfgRecipY:   ry_q   <= cfg_data_i[31:0];
        CfgRecipZ:   rz_q   <= cfg_data_i[31:0];
        default: ;
      endcase
    end
  end

  // store: address = bin*H + h, real and imaginary packed
  logic [95:0]   mem [Depth];
  logic          mem_we;
  logic [AW-1:0] mem_wa, mem_ra;
  logic [95:0]   mem_wd, mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_wa] <= mem_wd;
    mem_rd_q <= mem[mem_ra];
  end

  // shared multiplier: 33x33 signed gives the 64-bit products needed
  logic signed [32:0] mul_a, mul_b;
  logic signed [65:0] mul_p;
  logic [65:0]        mul_q;
  assign mul_p = mul_a * mul_b;
  always_ff @(posedge clk_i) mul_q <= mul_p;

  logic [3:0]  st_q, st_d;
  logic [5:0]  step_q;           // micro step within a bin
  logic [AW:0] cnt_q;            // clear sweep
  logic [GW-1:0] half_q;
  logic        planar_q;
  logic [NUM_HISTOGRAMS-1:0] hmask_q;
  logic [HW-1:0] h_q;
  logic signed [GW:0] nx_q, ny_q, nz_q;
  logic [63:0] px_q, py_q, pz_q, acc_q;
  logic [BW-1:0] bin_q;
  logic [31:0] ph_q, t_q, u_q, p_q;
  logic [15:0] sv_q, cv_q;       // Q15 magnitudes
  logic        pass_q;           // 0 sine of t, 1 sine of one minus t (the cosine)
  logic signed [47:0] cs_q, sn_q;
  sfa_in_t     item_q;
  sfa_out_t    out_q;
  logic        out_v_q;

  // grid size decode
  logic [4:0]    g_even;
  logic [GW-1:0] g_eff;
  always_comb begin
    g_even = {grid_q[4:1], 1'b0};
    if (32'(g_even) > MAX_GRID) g_eff = GW'(MAX_GRID);
    else                        g_eff = GW'(g_even);
  end

  // pair map lookup
  logic [NUM_HISTOGRAMS-1:0] hm;
  always_comb begin
    for (int h = 0; h < NUM_HISTOGRAMS; h++) begin
      int unsigned b;
      b = (32'(in_data_i.first_type) * NUM_TYPES + 32'(in_data_i.second_type))
          * NUM_HISTOGRAMS + h;
      hm[h] = (32'(in_data_i.first_type) < NUM_TYPES) &&
              (32'(in_data_i.second_type) < NUM_TYPES) &&
              (b < 64) && map_q[b[5:0]];
    end
  end

  logic accept;
  assign in_stall_o = (st_q != SIdle) || out_v_q;
  assign accept     = in_valid_i && !in_stall_o;

  // sine sequence: each Horner term issues a multiply, then takes the
  // registered product in the next cycle
  logic [31:0] tt;
  assign tt = pass_q ? (32'h4000_0000 - t_q) : t_q;
  logic [63:0] mq64;
  assign mq64 = mul_q[63:0];
  logic [33:0] s_rnd;
  assign s_rnd = 34'(mq64 >> 30) + 34'd16384;

  // saturating adds
  function automatic logic signed [47:0] sat_add(logic signed [47:0] a,
                                                 logic signed [47:0] b);
    logic signed [48:0] r;
    r = {a[47], a} + {b[47], b};
    if (r[48] != r[47]) sat_add = r[48] ? {1'b1, 47'd0} : {1'b0, {47{1'b1}}};
    else                sat_add = r[47:0];
  endfunction

  // multiplier operand select
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (st_q)
      SPre: begin
        unique case (step_q[1:0])
          2'd0: begin mul_a = {item_q.disp_x[31], item_q.disp_x}; mul_b = {1'b0, rx_q}; end
          2'd1: begin mul_a = {item_q.disp_y[31], item_q.disp_y}; mul_b = {1'b0, ry_q}; end
          default: begin mul_a = {item_q.disp_z[31], item_q.disp_z}; mul_b = {1'b0, rz_q}; end
        endcase
      end
      SSin: begin
        unique case (step_q[3:0])
          4'd0:  begin mul_a = {1'b0, tt}; mul_b = {1'b0, tt}; end
          4'd10: begin mul_a = {1'b0, p_q}; mul_b = {1'b0, tt}; end
          default: begin mul_a = {1'b0, p_q}; mul_b = {1'b0, u_q}; end
        endcase
      end
      default: ;
    endcase
  end

  // coefficient taken with the product of each Horner step
  logic [31:0] coef;
  always_comb begin
    case (step_q[3:0])
      4'd3: coef = Coef7;
      4'd5: coef = Coef5;
      4'd7: coef = Coef3;
      default: coef = Coef1;
    endcase
  end

  // index product for phase: n * p mod 2^64; the index is only a few bits wide
  logic [63:0] psel;
  logic signed [GW:0] nsel;
  always_comb begin
    unique case (step_q[2:1])
      2'd0:    begin psel = px_q; nsel = nx_q; end
      2'd1:    begin psel = py_q; nsel = ny_q; end
      default: begin psel = pz_q; nsel = nz_q; end
    endcase
  end
  logic [63:0] nprod;
  assign nprod = 64'(signed'(nsel)) * psel;   // narrow index times 64 bits

  logic signed [47:0] cv48, sv48;
  always_comb begin
    logic signed [47:0] s, c;
    s = 48'(sv_q);
    c = 48'(cv_q);
    unique case (ph_q[31:30])
      2'd0: begin cv48 = c;  sv48 = s;  end
      2'd1: begin cv48 = -s; sv48 = c;  end
      2'd2: begin cv48 = -c; sv48 = -s; end
      default: begin cv48 = s; sv48 = -c; end
    endcase
  end

  logic last_bin;
  assign last_bin = planar_q
    ? (nx_q == $signed({1'b0, half_q}) - 1 && ny_q == $signed({1'b0, half_q}))
    : (nx_q == $signed({1'b0, half_q}) - 1 && ny_q == $signed({1'b0, half_q}) - 1
       && nz_q == $signed({1'b0, half_q}));

  always_comb begin
    st_d   = st_q;
    mem_we = 1'b0;
    mem_wa = '0;
    mem_wd = '0;
    mem_ra = AW'(32'(bin_q) * NUM_HISTOGRAMS + 32'(h_q));
    unique case (st_q)
      SIdle: begin
        mem_ra = AW'(32'(in_data_i.bin_select) * NUM_HISTOGRAMS
                     + 32'(in_data_i.histogram_select));
        if (accept) begin
          unique case (in_data_i.mode)
            ModeClear: st_d = SClear;
            ModeAccum: st_d = (g_eff >= GW'(2) && hm != '0) ? SPre : SIdle;
            ModeRead:  st_d = SRdA;
            default:   st_d = SIdle;
          endcase
        end
      end
      SClear: begin
        mem_we = 1'b1;
        mem_wa = AW'(cnt_q);
        if (32'(cnt_q) == Depth - 1) st_d = SIdle;
      end
      SRdA: begin
        mem_ra = AW'(32'(item_q.bin_select) * NUM_HISTOGRAMS
                     + 32'(item_q.histogram_select));
        st_d   = SRdB;
      end
      SRdB: st_d = SIdle;
      SPre: if (step_q == 6'd3) st_d = SPh;
      SPh:  if (step_q == 6'd5) st_d = SSin;
      SSin: if (step_q == 6'd11 && pass_q) st_d = SHist;
      SHist: begin
        if (hmask_q[h_q]) st_d = SHRd;
        else if (32'(h_q) == NUM_HISTOGRAMS - 1) st_d = SOut;
      end
      SHRd: st_d = SHWr;
      SHWr: begin
        mem_we = 1'b1;
        mem_wa = AW'(32'(bin_q) * NUM_HISTOGRAMS + 32'(h_q));
        mem_wd = {sat_add(mem_rd_q[95:48], cs_q), sat_add(mem_rd_q[47:0], sn_q)};
        st_d   = (32'(h_q) == NUM_HISTOGRAMS - 1) ? SOut : SHist;
      end
      SOut: st_d = last_bin ? SIdle : SPh;
      default: st_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q    <= SClear;
      cnt_q   <= '0;
      step_q  <= '0;
      out_v_q <= 1'b0;
      h_q     <= '0;
      pass_q  <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_v_q && !out_stall_i) out_v_q <= 1'b0;
      unique case (st_q)
        SIdle: begin
          cnt_q  <= '0;
          step_q <= '0;
          h_q    <= '0;
          pass_q <= 1'b0;
          if (accept) begin
            item_q   <= in_data_i;
            hmask_q  <= hm;
            half_q   <= g_eff >> 1;
            planar_q <= (dims_q == 2'd2);
            nx_q     <= -$signed({1'b0, g_eff >> 1});
            ny_q     <= (dims_q == 2'd2) ? '0 : -$signed({1'b0, g_eff >> 1});
            nz_q     <= '0;
            // bins are walked in index order, so the bin is a plain count
            bin_q    <= '0;
          end
        end
        SClear: cnt_q <= cnt_q + 1'b1;
        SRdB: begin
          out_v_q <= 1'b1;
          if (32'(item_q.bin_select) < BinCount &&
              32'(item_q.histogram_select) < NUM_HISTOGRAMS) begin
            out_q.real_sum <= mem_rd_q[95:48];
            out_q.imag_sum <= mem_rd_q[47:0];
          end else begin
            out_q <= '0;
          end
        end
        SPre: begin
          step_q <= (step_q == 6'd3) ? '0 : step_q + 1'b1;
          if (step_q == 6'd1) px_q <= mul_q[63:0];
          if (step_q == 6'd2) py_q <= mul_q[63:0];
          if (step_q == 6'd3) pz_q <= mul_q[63:0];
        end
        SPh: begin
          // step 0 loads, steps 2 and 4 each add one axis term (step 4 not when planar)
          step_q <= (step_q == 6'd5) ? '0 : step_q + 1'b1;
          if (step_q == 6'd0) acc_q <= nprod;
          else if (step_q == 6'd2) acc_q <= acc_q + nprod;
          else if (step_q == 6'd4 && !planar_q) acc_q <= acc_q + nprod;
          if (step_q == 6'd5) begin
            ph_q  <= acc_q[47:16];
            t_q   <= {2'b00, acc_q[45:16]};
          end
        end
        SSin: begin
          step_q <= (step_q == 6'd11) ? '0 : step_q + 1'b1;
          unique case (step_q[3:0])
            4'd0: p_q <= Coef9;
            4'd1: u_q <= 32'(mq64 >> 30);
            4'd3, 4'd5, 4'd7, 4'd9: p_q <= coef - 32'(mq64 >> 30);
            4'd11: begin
              if (!pass_q) sv_q <= (s_rnd[33:15] > 19'd32767) ? 16'd32767 : s_rnd[30:15];
              else         cv_q <= (s_rnd[33:15] > 19'd32767) ? 16'd32767 : s_rnd[30:15];
              pass_q <= !pass_q;
            end
            default: ;
          endcase
        end
        SHist: begin
          cs_q <= cv48;
          sn_q <= sv48;
          if (!hmask_q[h_q] && 32'(h_q) != NUM_HISTOGRAMS - 1) h_q <= h_q + 1'b1;
        end
        SHWr: if (32'(h_q) != NUM_HISTOGRAMS - 1) h_q <= h_q + 1'b1;
        SOut: begin
          h_q   <= '0;
          bin_q <= bin_q + 1'b1;
          if (planar_q) begin
            if (ny_q == $signed({1'b0, half_q})) begin
              ny_q <= '0;
              nx_q <= nx_q + 1'b1;
            end else ny_q <= ny_q + 1'b1;
          end else if (nz_q == $signed({1'b0, half_q})) begin
            nz_q <= '0;
            if (ny_q == $signed({1'b0, half_q}) - 1) begin
              ny_q <= -$signed({1'b0, half_q});
              nx_q <= nx_q + 1'b1;
            end else ny_q <= ny_q + 1'b1;
          end else nz_q <= nz_q + 1'b1;
        end
        default: ;
      endcase
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

`ifndef ASSERT_OFF
  a_no_out_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> in_stall_o) else $error("item taken while result pending");
  a_out_from_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_v_q) |-> $past(st_q) == SRdB) else $error("result without read");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && $past(out_v_q && out_stall_i) |-> $stable(out_q))
    else $error("result changed while stalled");
`endif

endmodule

// ----- tb/structure_factor_accumulator_unit_tb.sv -----
module structure_factor_accumulator_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sfa_pkg::*;

  localparam logic [1:0] ModeIgnored = 2'd3;
  localparam int unsigned BinCount = MaxGrid * MaxGrid * (MaxGrid / 2 + 1);
  localparam longint SumMax = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint SumMin = -64'sh0000_8000_0000_0000;

  typedef struct {
    bit          is_cfg;
    logic [2:0]  idx;
    logic [63:0] val;
    sfa_in_t     beat;
    bit          fixed;
    sfa_out_t    want;
  } row_t;

  typedef struct {
    bit       fixed;
    sfa_out_t want;
  } typed_exp_t;

  logic     clk_i = 1'b0;
  logic     rst_ni = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  sfa_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  sfa_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;

  // shadow configuration and sums
  logic [4:0]  grid_cfg;
  logic [1:0]  dims_cfg;
  logic [63:0] pair_map_cfg;
  logic [31:0] recip_x_cfg, recip_y_cfg, recip_z_cfg;
  longint      real_acc [NumHistograms][BinCount];
  longint      imag_acc [NumHistograms][BinCount];

  sfa_out_t   bin_sums_q [$];
  typed_exp_t typed_q [$];
  row_t       rows [$];

  int  errors = 0;
  int  beats_sent = 0;
  int  reads_checked = 0;
  int  cfg_writes = 0;
  bit  quiet = 1'b0;
  bit  hold_req = 1'b0;
  bit  dirty = 1'b0;

  structure_factor_accumulator_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_o (cfg_ready),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data)
  );

  always #1 clk_i = ~clk_i;

  initial begin
    #20ms;
    $display("timeout waiting on the block");
    $display("CHECK FAILED");
    $finish;
  end

  function automatic longint quarter_wave(bit [63:0] t);
    bit [63:0] u, p, s;
    u = (t * t) >> 30;
    p = 64'(Coef9);
    p = 64'(Coef7) - ((p * u) >> 30);
    p = 64'(Coef5) - ((p * u) >> 30);
    p = 64'(Coef3) - ((p * u) >> 30);
    p = 64'(Coef1) - ((p * u) >> 30);
    s = (p * t) >> 30;
    s = (s + 64'd16384) >> 15;
    if (s > 64'd32767) s = 64'd32767;
    return longint'(s);
  endfunction

  function automatic longint sat_add(longint a, longint v);
    longint r;
    r = a + v;
    if (r > SumMax) r = SumMax;
    if (r < SumMin) r = SumMin;
    return r;
  endfunction

  function automatic void clear_sums();
    foreach (real_acc[h, b]) begin
      real_acc[h][b] = 0;
      imag_acc[h][b] = 0;
    end
  endfunction

  function automatic void accumulate_pair(sfa_in_t it);
    int          g, half, nx, ny, nz, ylo, yhi, zmax, bin;
    bit [3:0]    hmask;
    bit          planar;
    longint      px, py, pz, acc, cv, sv, s, c;
    bit [63:0]   accb;
    bit [31:0]   phase;
    bit [63:0]   t;
    g = int'(grid_cfg) & ~1;
    if (g > int'(MaxGrid)) g = MaxGrid;
    if (g < 2) return;
    hmask = '0;
    for (int h = 0; h < NumHistograms; h++)
      hmask[h] = pair_map_cfg[(it.first_type * NumTypes + it.second_type) * NumHistograms + h];
    if (hmask == 0) return;
    planar = (dims_cfg == 2'd2);
    half = g / 2;
    px = longint'(it.disp_x) * longint'({32'd0, recip_x_cfg});
    py = longint'(it.disp_y) * longint'({32'd0, recip_y_cfg});
    pz = longint'(it.disp_z) * longint'({32'd0, recip_z_cfg});
    ylo = planar ? 0 : -half;
    yhi = planar ? half + 1 : half;
    zmax = planar ? 0 : half;
    for (nx = -half; nx < half; nx++)
      for (ny = ylo; ny < yhi; ny++)
        for (nz = 0; nz <= zmax; nz++) begin
          acc = longint'(nx) * px + longint'(ny) * py;
          if (planar) begin
            bin = ny + (half + 1) * (nx + half);
          end else begin
            acc += longint'(nz) * pz;
            bin = nz + (half + 1) * ((ny + half) + g * (nx + half));
          end
          accb = acc;
          phase = accb[47:16];
          t = {34'd0, phase[29:0]};
          s = quarter_wave(t);
          c = quarter_wave(64'd1073741824 - t);
          case (phase[31:30])
            2'd0: begin cv = c;  sv = s;  end
            2'd1: begin cv = -s; sv = c;  end
            2'd2: begin cv = -c; sv = -s; end
            default: begin cv = s; sv = -c; end
          endcase
          for (int h = 0; h < NumHistograms; h++)
            if (hmask[h]) begin
              real_acc[h][bin] = sat_add(real_acc[h][bin], cv);
              imag_acc[h][bin] = sat_add(imag_acc[h][bin], sv);
            end
        end
  endfunction

  function automatic sfa_out_t read_bin(sfa_in_t it);
    sfa_out_t r;
    longint   re, im;
    r = '0;
    if (it.bin_select < BinCount) begin
      re = real_acc[it.histogram_select][it.bin_select];
      im = imag_acc[it.histogram_select][it.bin_select];
      r.real_sum = re[47:0];
      r.imag_sum = im[47:0];
    end
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [47:0] got, logic [47:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, $signed(got), $signed(want),
             $realtime);
    errors++;
  endtask

  // input beats update the shadow sums in acceptance order
  always @(posedge clk_i) begin
    typed_exp_t te;
    sfa_out_t   e;
    if (rst_ni && in_valid && !in_stall) begin
      te = typed_q.pop_front();
      case (in_data.mode)
        ModeClear: clear_sums();
        ModeAccum: accumulate_pair(in_data);
        ModeRead: begin
          e = read_bin(in_data);
          bin_sums_q.push_back(te.fixed ? te.want : e);
        end
        default: ;
      endcase
    end
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CfgGridSize: grid_cfg = cfg_data[4:0];
        CfgDims:     dims_cfg = cfg_data[1:0];
        CfgPairMap:  pair_map_cfg = cfg_data;
        CfgRecipX:   recip_x_cfg = cfg_data[31:0];
        CfgRecipY:   recip_y_cfg = cfg_data[31:0];
        CfgRecipZ:   recip_z_cfg = cfg_data[31:0];
        default: ;
      endcase
    end
  end

  always @(posedge clk_i) begin
    sfa_out_t w;
    if (rst_ni && out_valid && !out_stall) begin
      if (bin_sums_q.size() == 0) begin
        $display("unexpected result beat at %0t", $realtime);
        errors++;
      end else begin
        w = bin_sums_q.pop_front();
        reads_checked++;
        if (out_data.real_sum !== w.real_sum)
          report_mismatch("real_sum", out_data.real_sum, w.real_sum);
        if (out_data.imag_sum !== w.imag_sum)
          report_mismatch("imag_sum", out_data.imag_sum, w.imag_sum);
      end
    end
  end

  // result side: short random stalls, one long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (300) @(posedge clk_i);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!quiet && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic sfa_in_t mk(logic [1:0] mode, logic [1:0] ti, logic [1:0] tj,
                                 logic [31:0] x, logic [31:0] y, logic [31:0] z,
                                 logic [11:0] bin, logic [1:0] h);
    sfa_in_t r;
    r.mode = mode;
    r.first_type = ti;
    r.second_type = tj;
    r.disp_x = x;
    r.disp_y = y;
    r.disp_z = z;
    r.bin_select = bin;
    r.histogram_select = h;
    return r;
  endfunction

  function automatic void add_item(sfa_in_t it, bit fixed = 0, sfa_out_t want = '0);
    row_t r;
    r = '{default: '0};
    r.beat = it;
    r.fixed = fixed;
    r.want = want;
    rows.push_back(r);
  endfunction

  function automatic void add_cfg(logic [2:0] idx, logic [63:0] val);
    row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx = idx;
    r.val = val;
    rows.push_back(r);
  endfunction

  task automatic send_beat(sfa_in_t it, bit fixed = 0, sfa_out_t want = '0);
    bit ok;
    typed_exp_t te;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk_i);
    end
    te.fixed = fixed;
    te.want = want;
    typed_q.push_back(te);
    in_valid <= 1'b1;
    in_data <= it;
    do begin
      @(negedge clk_i);
      ok = !in_stall;
      @(posedge clk_i);
    end while (!ok);
    beats_sent++;
    dirty = 1'b1;
  endtask

  // a read drains everything queued ahead of it, so its result marks idle
  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    bit ok;
    if (dirty) begin
      send_beat(mk(ModeRead, 2'd0, 2'd0, '0, '0, '0, 12'd0, 2'd0));
      in_valid <= 1'b0;
      while (bin_sums_q.size() != 0) @(posedge clk_i);
      repeat (20) @(posedge clk_i);
      dirty = 1'b0;
    end
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do begin
      @(negedge clk_i);
      ok = cfg_ready;
      @(posedge clk_i);
    end while (!ok);
    cfg_valid <= 1'b0;
    cfg_writes++;
  endtask

  function automatic int built_bins();
    int g;
    g = int'(grid_cfg) & ~1;
    if (g > int'(MaxGrid)) g = MaxGrid;
    if (g < 2) return 0;
    return (dims_cfg == 2'd2) ? g * (g / 2 + 1) : g * g * (g / 2 + 1);
  endfunction

  initial begin
    sfa_out_t    zero, flat;
    logic [4:0]  g;
    logic [1:0]  d;
    logic [63:0] pm;
    int          nb, pick, ph;
    logic [11:0] bsel;
    zero = '0;
    flat.real_sum = 48'sd32767;
    flat.imag_sum = '0;
    grid_cfg = 5'd16;
    dims_cfg = 2'd3;
    pair_map_cfg = '1;
    recip_x_cfg = '0;
    recip_y_cfg = '0;
    recip_z_cfg = '0;
    clear_sums();

    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd0, 2'd0), 1, zero);
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd2303, 2'd3), 1, zero);
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd4095, 2'd1), 1, zero);
    add_item(mk(ModeIgnored, 3, 3, '1, '1, '1, 12'd5, 2'd2));
    add_cfg(CfgGridSize, 64'd2);
    add_cfg(CfgPairMap, '1);
    // zero phase everywhere: every bin gets cos 1, sin 0
    add_item(mk(ModeAccum, 0, 0, 0, 0, 0, 0, 0));
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd0, 2'd0), 1, flat);
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd7, 2'd2), 1, flat);
    add_cfg(CfgRecipX, 64'hFFFF_FFFF);
    add_cfg(CfgRecipY, 64'h8000_0000);
    add_cfg(CfgRecipZ, 64'd1);
    add_item(mk(ModeAccum, 3, 3, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 0, 0));
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd5, 2'd3));
    add_cfg(CfgPairMap, 64'd1);
    add_item(mk(ModeAccum, 1, 2, 32'h0003_4000, 32'hFFFE_0000, 32'h0000_8000, 0, 0));
    add_item(mk(ModeAccum, 0, 0, 32'h1234_5678, 32'h0001_0000, 32'hF000_0000, 0, 0));
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd3, 2'd1));
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd3, 2'd0));
    // oversized odd grid saturates; planar keeps it short
    add_cfg(CfgDims, 64'd2);
    add_cfg(CfgGridSize, 64'd31);
    add_item(mk(ModeAccum, 0, 0, 32'h0001_0000, 32'h0002_8000, 32'h0, 0, 0));
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd143, 2'd0));
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd144, 2'd0));
    add_cfg(CfgGridSize, 64'd1);
    add_item(mk(ModeAccum, 0, 0, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 0, 0));
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd0, 2'd0));
    add_cfg(CfgDims, 64'd0);
    add_cfg(CfgGridSize, 64'd3);
    add_item(mk(ModeAccum, 0, 0, 32'h0000_4000, 32'h7000_0000, 32'h8000_0001, 0, 0));
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd6, 2'd0));
    add_item(mk(ModeClear, 0, 0, 0, 0, 0, 0, 0));
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd0, 2'd0), 1, zero);
    add_item(mk(ModeRead, 0, 0, 0, 0, 0, 12'd2303, 2'd3), 1, zero);

    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].is_cfg) write_reg(rows[i].idx, rows[i].val);
      else send_beat(rows[i].beat, rows[i].fixed, rows[i].want);
    end

    for (ph = 0; ph < 11; ph++) begin
      quiet = (ph >= 9);
      d = 2'($urandom_range(0, 3));
      if (d == 2'd2) g = 5'($urandom_range(0, 31));
      else begin
        pick = $urandom_range(0, 9);
        g = (pick < 5) ? 5'd2 : (pick < 8) ? 5'd4 : (pick == 8) ? 5'd6 : 5'($urandom_range(0, 5));
      end
      case ($urandom_range(0, 2))
        0: pm = '1;
        1: pm = {$urandom, $urandom};
        default: pm = {$urandom, $urandom} & {$urandom, $urandom};
      endcase
      write_reg(CfgGridSize, 64'(g));
      write_reg(CfgDims, 64'(d));
      write_reg(CfgPairMap, pm);
      write_reg(CfgRecipX, $urandom_range(0, 1) ? 64'($urandom) : 64'($urandom_range(0, 65535)));
      write_reg(CfgRecipY, $urandom_range(0, 1) ? 64'($urandom) : 64'($urandom_range(0, 65535)));
      write_reg(CfgRecipZ, $urandom_range(0, 1) ? 64'($urandom) : 64'($urandom_range(0, 65535)));
      nb = built_bins();
      if (ph == 4) begin
        // results held back: the block fills and stalls its input
        hold_req = 1'b1;
        repeat (6) send_beat(mk(ModeRead, 0, 0, 0, 0, 0, 12'($urandom_range(0, 4095)),
                                2'($urandom_range(0, 3))));
      end
      repeat (22) begin
        pick = $urandom_range(0, 19);
        if (nb > 0 && $urandom_range(0, 4) != 0) bsel = 12'($urandom_range(0, nb - 1));
        else bsel = 12'($urandom_range(0, 4095));
        if (pick < 8)
          send_beat(mk(ModeAccum, 2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)),
                       $urandom, $urandom, $urandom, 12'($urandom), 2'($urandom)));
        else if (pick < 18)
          send_beat(mk(ModeRead, 2'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
                       bsel, 2'($urandom_range(0, 3))));
        else if (pick == 18)
          send_beat(mk(ModeClear, 2'($urandom), 2'($urandom), $urandom, $urandom, $urandom,
                       12'($urandom), 2'($urandom)));
        else
          send_beat(mk(ModeIgnored, 2'($urandom), 2'($urandom), $urandom, $urandom,
                       $urandom, 12'($urandom), 2'($urandom)));
      end
    end
    in_valid <= 1'b0;

    while (bin_sums_q.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    $display("%0d input beats, %0d register writes, %0d bin reads compared", beats_sent,
             cfg_writes, reads_checked);
    $display("covered clear, accumulate, read, ignored mode, odd/oversized/tiny grids, 2-D and 3-D");
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
hw/rtl/sfa_pkg.sv
hw/rtl/structure_factor_accumulator_unit.sv
tb/structure_factor_accumulator_unit_tb.sv
